// File: hw/rtl/pidfd_pkg.sv
// Shared types, constants and helpers of the filtered-derivative PID controller.
package pidfd_pkg;

   // Datapath widths
   localparam int OPR_W  = 33;          // multiplier operand, signed
   localparam int PROD_W = 2 * OPR_W;   // full product
   localparam int ACC_W  = 51;          // accumulator, holds four floored terms
   localparam int Q_SH   = 16;          // Q16.16 fraction bits
   localparam int REG_W  = 3;           // configuration index width
   localparam int PC_W   = 4;           // microprogram counter width

   // Serial divider: 48 dividend bits, two quotient bits per cycle
   localparam int DIV_BITS  = 48;
   localparam int DIV_STEPS = DIV_BITS / 2;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [16:0] Q_ONE = 17'h1_0000;

   localparam logic signed [ACC_W-1:0] ACC_S32_MAX = ACC_W'(32'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] ACC_S32_MIN = ACC_W'(32'sh8000_0000);

   // Configuration register indexes
   typedef enum logic [REG_W-1:0] {
      REG_GAIN_P    = 3'd0,
      REG_GAIN_I    = 3'd1,
      REG_GAIN_D    = 3'd2,
      REG_GAIN_FF   = 3'd3,
      REG_INT_LIMIT = 3'd4,
      REG_ALPHA     = 3'd5
   } reg_idx_type;

   // Multiplier operand pairs
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_ERR_DT,
      MUL_P,
      MUL_I,
      MUL_D,
      MUL_FF,
      MUL_ALPHA_Q,
      MUL_BETA_F
   } mul_sel_type;

   // Accumulator operations
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_RAW,
      ACC_ADD_RAW,
      ACC_LOAD_SH,
      ACC_ADD_SH,
      ACC_SUB_SH
   } acc_op_type;

   // Datapath actions
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_DIV_START,
      ACT_INTEG,
      ACT_FILT_WR,
      ACT_FILT_ZERO,
      ACT_EMIT,
      ACT_EMIT_SKIP
   } act_type;

   // Jump conditions
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_SKIP,
      C_FIRST,
      C_DIV_BUSY,
      C_OUT_FULL
   } cond_type;

   // One microcode word
   typedef struct packed {
      mul_sel_type       mul;
      acc_op_type        acc;
      act_type           act;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } uword_type;

   // Control from sequencer to datapath
   typedef struct packed {
      logic        en;
      mul_sel_type mul;
      acc_op_type  acc;
      act_type     act;
   } ctl_type;

   // Status from datapath to sequencer
   typedef struct packed {
      logic skip;
      logic first;
      logic div_busy;
      logic out_full;
   } stat_type;

   // Configuration registers
   typedef struct packed {
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic signed [31:0] gain_ff;
      logic        [30:0] int_limit;
      logic        [16:0] alpha;
   } cfg_type;

   // One latched request
   typedef struct packed {
      logic               op;
      logic signed [31:0] err;
      logic        [15:0] dt;
      logic signed [31:0] ff;
   } item_type;

   // Saturate an accumulator-width value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > ACC_S32_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < ACC_S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/pidfd_div.sv
// Radix-4 restoring divider for the derivative quotient, truncating toward zero.
module pidfd_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [32:0]  diff,
   input  logic        [15:0]  divisor,
   output logic                busy,
   output logic signed [31:0]  quot
);
   import pidfd_pkg::*;

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [15:0]         rem_ff, rem_in;
   logic [DIV_BITS-1:0] num_ff, num_in;
   logic [15:0]         den_ff, den_in;
   logic                neg_ff, neg_in;

   logic [32:0]         mag;
   logic [16:0]         r1, r2;
   logic [15:0]         r1_left;
   logic                ge1, ge2;

   // Two quotient bits per cycle
   always_comb begin
      r1  = {rem_ff, num_ff[DIV_BITS-1]};
      ge1 = r1 >= {1'b0, den_ff};
      r1_left = ge1 ? 16'(r1 - {1'b0, den_ff}) : r1[15:0];
      r2  = {r1_left, num_ff[DIV_BITS-2]};
      ge2 = r2 >= {1'b0, den_ff};
   end

   // Load on start, iterate while busy
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      mag     = diff[32] ? 33'(-diff) : diff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         num_in  = {mag[31:0], 16'h0000};
         den_in  = divisor;
         neg_in  = diff[32];
      end else if (busy_ff) begin
         rem_in = ge2 ? 16'(r2 - {1'b0, den_ff}) : r2[15:0];
         num_in = {num_ff[DIV_BITS-3:0], ge1, ge2};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Apply sign and saturate to 32 bits
   always_comb begin
      if (neg_ff) begin
         quot = (num_ff > DIV_BITS'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-num_ff[31:0]);
      end else begin
         quot = (num_ff > DIV_BITS'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : num_ff[31:0];
      end
   end

   assign busy = busy_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_finish : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_W'(DIV_STEPS - 1)) |=> !busy_ff)
      else $error("divider ran past its last step");

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider step count out of range");

endmodule

// File: hw/rtl/pidfd_dp.sv
// Datapath: shared multiplier, accumulator, controller state and divider.
module pidfd_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  pidfd_pkg::ctl_type   ctl,
   input  pidfd_pkg::cfg_type   cfg,
   input  pidfd_pkg::item_type  item,
   input  logic                 out_full,
   output pidfd_pkg::stat_type  stat,
   output logic                 res_valid,
   output logic signed [31:0]   res_drive,
   output logic                 res_skipped
);
   import pidfd_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]       integ_ff, integ_in;
   logic signed [31:0]       last_ff, last_in;
   logic signed [31:0]       filt_ff, filt_in;
   logic                     first_ff, first_in;

   logic signed [OPR_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [ACC_W-1:0]  prod_sh, prod_raw;
   logic [16:0]              alpha_c, beta;
   logic signed [32:0]       isum, ilim;
   logic signed [32:0]       diff;
   logic                     div_start, div_busy;
   logic signed [31:0]       div_quot;

   // Clamp the filter weight to one
   assign alpha_c = (cfg.alpha[16] && |cfg.alpha[15:0]) ? Q_ONE : cfg.alpha;
   assign beta    = Q_ONE - alpha_c;

   // Select the operand pair
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.mul)
         MUL_ERR_DT: begin
            mul_a = OPR_W'(item.err);
            mul_b = {17'h0, item.dt};
         end
         MUL_P: begin
            mul_a = OPR_W'(cfg.gain_p);
            mul_b = OPR_W'(item.err);
         end
         MUL_I: begin
            mul_a = OPR_W'(cfg.gain_i);
            mul_b = OPR_W'(integ_ff);
         end
         MUL_D: begin
            mul_a = OPR_W'(cfg.gain_d);
            mul_b = OPR_W'(filt_ff);
         end
         MUL_FF: begin
            mul_a = OPR_W'(cfg.gain_ff);
            mul_b = OPR_W'(item.ff);
         end
         MUL_ALPHA_Q: begin
            mul_a = {16'h0, alpha_c};
            mul_b = OPR_W'(div_quot);
         end
         MUL_BETA_F: begin
            mul_a = {16'h0, beta};
            mul_b = OPR_W'(filt_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_sh  = ACC_W'(prod_ff >>> Q_SH);
   assign prod_raw = ACC_W'(prod_ff);
   assign diff     = 33'(item.err) - 33'(last_ff);

   // Integral update: add floored error * dt, clamp to the symmetric limit
   always_comb begin
      isum = 33'(integ_ff) + 33'(prod_sh);
      ilim = {2'b00, cfg.int_limit};
   end

   // Multiplier register and accumulator
   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (ctl.en && ctl.mul != MUL_NONE) begin
         prod_in = mul_p;
      end
      if (ctl.en) begin
         unique case (ctl.acc)
            ACC_LOAD_RAW: acc_in = prod_raw;
            ACC_ADD_RAW:  acc_in = acc_ff + prod_raw;
            ACC_LOAD_SH:  acc_in = prod_sh;
            ACC_ADD_SH:   acc_in = acc_ff + prod_sh;
            ACC_SUB_SH:   acc_in = acc_ff - prod_sh;
            default:      acc_in = acc_ff;
         endcase
      end
   end

   // Actions on state and result
   always_comb begin
      integ_in    = integ_ff;
      last_in     = last_ff;
      filt_in     = filt_ff;
      first_in    = first_ff;
      div_start   = 1'b0;
      res_valid   = 1'b0;
      res_drive   = '0;
      res_skipped = 1'b0;
      if (ctl.en) begin
         unique case (ctl.act)
            ACT_DIV_START: div_start = 1'b1;
            ACT_INTEG: begin
               if (isum > ilim) begin
                  integ_in = ilim[31:0];
               end else if (isum < -ilim) begin
                  integ_in = 32'(-ilim);
               end else begin
                  integ_in = isum[31:0];
               end
            end
            ACT_FILT_WR:   filt_in = sat32(ACC_W'(acc_ff >>> Q_SH));
            ACT_FILT_ZERO: begin
               filt_in  = '0;
               first_in = 1'b0;
            end
            ACT_EMIT: begin
               res_valid = 1'b1;
               res_drive = sat32(acc_ff);
               last_in   = item.err;
            end
            ACT_EMIT_SKIP: begin
               res_valid   = 1'b1;
               res_skipped = 1'b1;
               if (item.op) begin
                  integ_in = '0;
                  last_in  = '0;
                  filt_in  = '0;
                  first_in = 1'b1;
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
         filt_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         integ_ff <= integ_in;
         last_ff  <= last_in;
         filt_ff  <= filt_in;
         first_ff <= first_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   pidfd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .diff    (diff),
      .divisor (item.dt),
      .busy    (div_busy),
      .quot    (div_quot)
   );

   always_comb begin
      stat.skip     = item.op || (item.dt == 16'h0000);
      stat.first    = first_ff;
      stat.div_busy = div_busy;
      stat.out_full = out_full;
   end

endmodule

// File: hw/rtl/pidfd_seq.sv
// Microcode sequencer: control store, step counter and conditional jumps.
module pidfd_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pidfd_pkg::stat_type stat,
   output pidfd_pkg::ctl_type  ctl,
   output logic                ready
);
   import pidfd_pkg::*;

   localparam logic [PC_W-1:0] S_DIV_WAIT = 4'd2;
   localparam logic [PC_W-1:0] S_FIRST    = 4'd7;
   localparam logic [PC_W-1:0] S_TERMS    = 4'd8;
   localparam logic [PC_W-1:0] S_EMIT     = 4'd13;
   localparam logic [PC_W-1:0] S_SKIP     = 4'd14;

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uw;
   logic            hold, taken, done;

   function automatic uword_type mk(input mul_sel_type m, input acc_op_type a,
                                    input act_type t, input cond_type c,
                                    input logic [PC_W-1:0] tg);
      uword_type w;
      w.mul    = m;
      w.acc    = a;
      w.act    = t;
      w.cond   = c;
      w.target = tg;
      return w;
   endfunction

   // Control store
   always_comb begin
      unique case (pc_ff)
         4'd0:  uw = mk(MUL_ERR_DT,  ACC_HOLD,     ACT_DIV_START, C_SKIP,     S_SKIP);
         4'd1:  uw = mk(MUL_NONE,    ACC_HOLD,     ACT_INTEG,     C_FIRST,    S_FIRST);
         4'd2:  uw = mk(MUL_NONE,    ACC_HOLD,     ACT_NONE,      C_DIV_BUSY, S_DIV_WAIT);
         4'd3:  uw = mk(MUL_ALPHA_Q, ACC_HOLD,     ACT_NONE,      C_NEVER,    '0);
         4'd4:  uw = mk(MUL_BETA_F,  ACC_LOAD_RAW, ACT_NONE,      C_NEVER,    '0);
         4'd5:  uw = mk(MUL_NONE,    ACC_ADD_RAW,  ACT_NONE,      C_NEVER,    '0);
         4'd6:  uw = mk(MUL_NONE,    ACC_HOLD,     ACT_FILT_WR,   C_ALWAYS,   S_TERMS);
         4'd7:  uw = mk(MUL_NONE,    ACC_HOLD,     ACT_FILT_ZERO, C_NEVER,    '0);
         4'd8:  uw = mk(MUL_P,       ACC_HOLD,     ACT_NONE,      C_NEVER,    '0);
         4'd9:  uw = mk(MUL_I,       ACC_LOAD_SH,  ACT_NONE,      C_NEVER,    '0);
         4'd10: uw = mk(MUL_D,       ACC_ADD_SH,   ACT_NONE,      C_NEVER,    '0);
         4'd11: uw = mk(MUL_FF,      ACC_SUB_SH,   ACT_NONE,      C_NEVER,    '0);
         4'd12: uw = mk(MUL_NONE,    ACC_ADD_SH,   ACT_NONE,      C_NEVER,    '0);
         4'd13: uw = mk(MUL_NONE,    ACC_HOLD,     ACT_EMIT,      C_OUT_FULL, S_EMIT);
         4'd14: uw = mk(MUL_NONE,    ACC_HOLD,     ACT_EMIT_SKIP, C_OUT_FULL, S_SKIP);
         default: uw = mk(MUL_NONE,  ACC_HOLD,     ACT_NONE,      C_NEVER,    '0);
      endcase
   end

   // Wait conditions stall the step and suppress its actions
   always_comb begin
      hold  = (uw.cond == C_DIV_BUSY && stat.div_busy) ||
              (uw.cond == C_OUT_FULL && stat.out_full);
      taken = (uw.cond == C_ALWAYS) || (uw.cond == C_SKIP && stat.skip) ||
              (uw.cond == C_FIRST && stat.first) || hold;
      done  = busy_ff && !hold && (uw.act == ACT_EMIT || uw.act == ACT_EMIT_SKIP);
   end

   // Advance the step counter
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end else if (done) begin
         busy_in = 1'b0;
         pc_in   = '0;
      end else if (taken) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   always_comb begin
      ctl.en  = busy_ff && !hold;
      ctl.mul = uw.mul;
      ctl.acc = uw.acc;
      ctl.act = uw.act;
   end

   assign ready = !busy_ff;

   a_pc_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= S_SKIP))
      else $error("step counter outside the program");

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("request taken without starting the program");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done |=> !busy_ff)
      else $error("sequencer stayed busy after its result");

endmodule

// File: hw/rtl/pid_filtered_derivative.sv
// Top level of the filtered-derivative PID controller.
//
// Requests arrive on req_* (tvalid/tready/tdata/tuser); one result per request
// leaves on rsp_*. tuser of a request is the op bit (1 clears the stored state).
// Gains, integral limit and derivative weight are written through csr_wen,
// csr_addr and csr_wdata; the user must do so only while the block is idle, a
// rule that the block itself leaves unenforced. An update request runs a 15-step
// microprogram on one shared 33x33 multiplier; the derivative quotient comes
// from a radix-4 serial divider, and the microprogram waits at its divider
// step until the quotient is ready. The first step after a clear does not
// wait for the quotient. A clear request or a zero time step jumps straight
// to the step that emits its result, which is registered on rsp_*.
// One request is in work at a time; req_tready is high whenever the
// microprogram is idle, even while a finished result waits on rsp_*.
// A stalled receiver holds the result register; the microprogram then waits
// at its final step until the register frees up.
// Reset (synchronous, active high) loads the default configuration, clears the
// integral, last error and filtered derivative, and arms the first-step flag.
module pid_filtered_derivative (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [79:0]                    req_tdata,  // error_in, step_time, feedforward_in
   input  logic                           req_tuser,  // op
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,  // drive
   output logic                           rsp_tuser,  // skipped
   input  logic                           csr_wen,
   input  logic [pidfd_pkg::REG_W-1:0]    csr_addr,
   input  logic [31:0]                    csr_wdata
);
   import pidfd_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   item_type           item_ff, item_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_drive_ff, rsp_drive_in;
   logic               rsp_skip_ff, rsp_skip_in;

   logic               accept, seq_ready;
   ctl_type            ctl;
   stat_type           stat;
   logic               res_valid, res_skipped;
   logic signed [31:0] res_drive;

   assign accept = req_tvalid && seq_ready;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            REG_GAIN_P:    cfg_in.gain_p    = csr_wdata;
            REG_GAIN_I:    cfg_in.gain_i    = csr_wdata;
            REG_GAIN_D:    cfg_in.gain_d    = csr_wdata;
            REG_GAIN_FF:   cfg_in.gain_ff   = csr_wdata;
            REG_INT_LIMIT: cfg_in.int_limit = csr_wdata[30:0];
            REG_ALPHA:     cfg_in.alpha     = csr_wdata[16:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Latch the request
   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.op  = req_tuser;
         item_in.err = req_tdata[31:0];
         item_in.dt  = req_tdata[47:32];
         item_in.ff  = req_tdata[79:48];
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_skip_in  = rsp_skip_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = res_drive;
         rsp_skip_in  = res_skipped;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p    <= '0;
         cfg_ff.gain_i    <= '0;
         cfg_ff.gain_d    <= '0;
         cfg_ff.gain_ff   <= '0;
         cfg_ff.int_limit <= 31'd65536000;
         cfg_ff.alpha     <= 17'd6554;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_skip_ff  <= rsp_skip_in;
   end

   pidfd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .stat  (stat),
      .ctl   (ctl),
      .ready (seq_ready)
   );

   pidfd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .cfg         (cfg_ff),
      .item        (item_ff),
      .out_full    (rsp_valid_ff && !rsp_tready),
      .stat        (stat),
      .res_valid   (res_valid),
      .res_drive   (res_drive),
      .res_skipped (res_skipped)
   );

   assign req_tready = seq_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = rsp_skip_ff;

endmodule

// File: bench/pidfd_checker.sv
// Checker of the filtered-derivative PID controller: snoops the ports, predicts and compares.
module pidfd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,   // error_in, step_time, feedforward_in
   input  logic        req_tuser,   // op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // drive
   input  logic        rsp_tuser,   // skipped
   input  logic        csr_wen,
   input  logic [pidfd_pkg::REG_W-1:0] csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pidfd_pkg::*;

   localparam logic   OP_CLEAR   = 1'b1;
   localparam longint ONE_Q16    = 65536;
   localparam longint LIM_RESET  = 65536000;
   localparam longint ALPHA_RST  = 6554;
   localparam int     PRINT_CAP  = 40;

   typedef struct {
      logic [31:0] drive;
      logic        skipped;
   } drive_item_type;

   // expected results, oldest first
   drive_item_type drive_due[$];

   // shadow configuration
   longint kp, ki, kd, kff, int_lim, alpha_w;

   // shadow controller state
   longint integ, prev_err, filt_d;
   bit     first_flag;

   function automatic longint floor16(longint v);
      return v >>> 16;
   endfunction

   function automatic longint clip32(longint v);
      longint r;
      r = v;
      if (v > 64'sd2147483647) begin
         r = 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         r = -64'sd2147483648;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      if (fail_count < PRINT_CAP) begin
         $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
      end
      fail_count++;
   endtask

   // Work out the drive for one accepted request and queue it
   function automatic void compute_drive(input logic op, input logic signed [31:0] err_in,
                                         input logic [15:0] dt_in,
                                         input logic signed [31:0] ff_in);
      drive_item_type res;
      longint e, d, f, pt, it, dterm, ft, acc, a, slope, total;
      e = longint'(err_in);
      d = longint'(dt_in);
      f = longint'(ff_in);
      res.drive = '0;
      res.skipped = 1'b1;
      if (op == OP_CLEAR) begin
         integ = 0;
         prev_err = 0;
         filt_d = 0;
         first_flag = 1'b1;
      end else if (d != 0) begin
         pt = floor16(kp * e);
         // integrate, then clamp symmetrically
         acc = integ + floor16(e * d);
         if (acc > int_lim) begin
            acc = int_lim;
         end
         if (acc < -int_lim) begin
            acc = -int_lim;
         end
         integ = acc;
         it = floor16(ki * integ);
         // low-pass the slope, held at zero on the first step
         if (!first_flag) begin
            slope = clip32(((e - prev_err) * ONE_Q16) / d);
            a = (alpha_w > ONE_Q16) ? ONE_Q16 : alpha_w;
            filt_d = clip32(floor16(a * slope + (ONE_Q16 - a) * filt_d));
         end else begin
            filt_d = 0;
            first_flag = 1'b0;
         end
         dterm = floor16(kd * filt_d);
         ft = floor16(kff * f);
         prev_err = e;
         total = clip32(pt + it - dterm + ft);
         res.drive = total[31:0];
         res.skipped = 1'b0;
      end
      drive_due = {drive_due, res};
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // Track configuration, check results, then predict new requests
   always @(posedge clock) begin
      drive_item_type want;
      if (reset) begin
         kp = 0;
         ki = 0;
         kd = 0;
         kff = 0;
         int_lim = LIM_RESET;
         alpha_w = ALPHA_RST;
         integ = 0;
         prev_err = 0;
         filt_d = 0;
         first_flag = 1'b1;
         drive_due.delete();
      end else begin
         if (csr_wen) begin
            case (reg_idx_type'(csr_addr))
               REG_GAIN_P:    kp = longint'($signed(csr_wdata));
               REG_GAIN_I:    ki = longint'($signed(csr_wdata));
               REG_GAIN_D:    kd = longint'($signed(csr_wdata));
               REG_GAIN_FF:   kff = longint'($signed(csr_wdata));
               REG_INT_LIMIT: int_lim = longint'(csr_wdata[30:0]);
               REG_ALPHA:     alpha_w = longint'(csr_wdata[16:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (drive_due.size() == 0) begin
               report_mismatch("unrequested result", 0, longint'(rsp_tdata));
            end else begin
               want = drive_due.pop_front();
               if (rsp_tdata !== want.drive) begin
                  report_mismatch("drive", longint'(want.drive), longint'(rsp_tdata));
               end
               if (rsp_tuser !== want.skipped) begin
                  report_mismatch("skipped", longint'(want.skipped), longint'(rsp_tuser));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            compute_drive(req_tuser, req_tdata[31:0], req_tdata[47:32], req_tdata[79:48]);
         end
      end
      pending = drive_due.size();
   end

endmodule

// File: bench/tb_pid_filtered_derivative.sv
// Testbench top of the filtered-derivative PID controller: stimulus, reset and verdict.
module tb_pid_filtered_derivative;
   timeunit 1ns;
   timeprecision 1ps;
   import pidfd_pkg::*;

   localparam logic OP_STEP    = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;
   localparam int   RESET_CYC  = 6;
   localparam int   SETTLE_CYC = 60;
   localparam int   LONG_HOLD  = 400;
   localparam int   PHASES     = 8;
   localparam int   PHASE_REQS = 230;
   localparam int   CALM_REQS  = 150;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [79:0]       req_tdata;   // error_in, step_time, feedforward_in
   logic              req_tuser;   // op
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;   // drive
   logic              rsp_tuser;   // skipped
   logic              csr_wen;
   logic [REG_W-1:0]  csr_addr;
   logic [31:0]       csr_wdata;

   int                fail_count;
   int                pending;
   bit                idle_on;
   int                hold_asked;
   int                hold_served;
   logic signed [31:0] err_walk;

   pid_filtered_derivative u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   pidfd_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Generous limit on the whole run
   initial begin
      #1_500_000;
      $display("Test completed with failures");
      $finish;
   end

   // Receiver: random hold-off bursts, plus a long hold on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_served++;
            rsp_tready = 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Write one register; entered and left at a falling edge
   task automatic set_reg(input reg_idx_type idx, input logic [31:0] val);
      csr_wen = 1'b1;
      csr_addr = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   task automatic load_config(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                              input logic [31:0] ff, input logic [30:0] lim,
                              input logic [16:0] alpha);
      set_reg(REG_GAIN_P, p);
      set_reg(REG_GAIN_I, i);
      set_reg(REG_GAIN_D, d);
      set_reg(REG_GAIN_FF, ff);
      set_reg(REG_INT_LIMIT, {1'b0, lim});
      set_reg(REG_ALPHA, {15'd0, alpha});
   endtask

   // Offer one request, with an optional gap first, and hold it until accepted
   task automatic send_request(input logic op, input logic [31:0] err, input logic [15:0] dt,
                               input logic [31:0] ff);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {ff, dt, err};
      req_tuser = op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering and wait for every expected result
   task automatic drain;
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return $urandom;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [30:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return 31'd0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom);
         default: return 31'($urandom_range(1, 32'h0100_0000));
      endcase
   endfunction

   function automatic logic [16:0] pick_alpha();
      case ($urandom_range(0, 6))
         0: return 17'd0;
         1: return 17'h1_0000;
         2: return 17'h1_FFFF;
         3: return 17'($urandom);
         default: return 17'($urandom_range(0, 32'h0001_0000));
      endcase
   endfunction

   // Mostly a slowly moving error with sane time steps, some noise and clears
   task automatic send_random_request;
      logic [31:0] err;
      logic [15:0] dt;
      logic        op;
      op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_STEP;
      case ($urandom_range(0, 15))
         0: dt = 16'd0;
         1: dt = 16'hFFFF;
         2, 3: dt = 16'($urandom_range(1, 8));
         default: dt = 16'($urandom_range(1, 16'hFFFF));
      endcase
      if ($urandom_range(0, 9) < 6) begin
         err_walk = err_walk + $signed($urandom_range(0, 16383) - 8192);
         err = err_walk;
      end else begin
         err = pick_sample();
      end
      send_request(op, err, dt, pick_sample());
   endtask

   // Main stimulus
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_STEP;
      csr_wen = 1'b0;
      csr_addr = REG_GAIN_P;
      csr_wdata = '0;
      idle_on = 1'b1;
      hold_asked = 0;
      hold_served = 0;
      err_walk = 32'sh0001_0000;
      repeat (RESET_CYC) @(negedge clock);
      reset = 1'b0;

      // a step and a clear on the reset configuration
      send_request(OP_STEP, 32'h0001_0000, 16'd655, 32'h0001_0000);
      send_request(OP_CLEAR, $urandom, 16'($urandom), $urandom);
      drain();

      // moderate gains: first step, filtered slope, zero step time, clear, extreme inputs
      load_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
                  31'd65536000, 17'h0_8000);
      send_request(OP_STEP, 32'h0001_0000, 16'd655, 32'h0000_0000);
      send_request(OP_STEP, 32'h0002_0000, 16'd655, 32'h0001_0000);
      send_request(OP_STEP, 32'h0003_0000, 16'd0, 32'h0002_0000);
      send_request(OP_CLEAR, $urandom, 16'($urandom), $urandom);
      send_request(OP_STEP, 32'hFFFF_0000, 16'd655, 32'h0000_0000);
      send_request(OP_STEP, 32'h7FFF_FFFF, 16'd1, 32'h7FFF_FFFF);
      send_request(OP_STEP, 32'h8000_0000, 16'd1, 32'h8000_0000);
      send_request(OP_STEP, 32'h8000_0000, 16'hFFFF, 32'h0000_0000);
      send_request(OP_STEP, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF);
      drain();

      // extreme gains, zero clamp, weight above one
      load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  31'd0, 17'h1_FFFF);
      send_request(OP_STEP, 32'h7FFF_FFFF, 16'd1, 32'h7FFF_FFFF);
      send_request(OP_STEP, 32'h8000_0000, 16'd1, 32'h8000_0000);
      send_request(OP_STEP, 32'h7FFF_FFFF, 16'd1, 32'h0000_0000);
      send_request(OP_CLEAR, 32'h0, 16'h0, 32'h0);
      send_request(OP_STEP, 32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF);
      drain();

      // opposite extremes, widest clamp, zero weight
      load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  31'h7FFF_FFFF, 17'd0);
      send_request(OP_STEP, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
      send_request(OP_STEP, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
      send_request(OP_STEP, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF);
      send_request(OP_STEP, 32'h8000_0000, 16'd1, 32'hFFFF_FFFF);
      send_request(OP_STEP, 32'h0000_0000, 16'd0, 32'hFFFF_FFFF);
      drain();

      // random phases, each on its own configuration
      for (int ph = 0; ph < PHASES; ph++) begin
         load_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                     pick_limit(), pick_alpha());
         idle_on = (ph % 3 != 2);
         if (ph == 3) begin
            hold_asked++;
         end
         for (int n = 0; n < PHASE_REQS; n++) begin
            send_random_request();
         end
         drain();
      end

      // closing part without any idling
      idle_on = 1'b0;
      load_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  pick_limit(), pick_alpha());
      for (int n = 0; n < CALM_REQS; n++) begin
         send_random_request();
      end
      drain();

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
